[rtl/pidc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Types, codes and saturation helpers shared by the PID controller modules.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int DW = 32;   // data width, Q16.16
  localparam int FB = 16;   // fractional bits
  localparam int AW = 48;   // integrator width
  localparam int TW = 24;   // time field width
  localparam int WW = 64;   // arithmetic unit operand width
  localparam int PW = 128;  // full product width
  localparam int XW = 80;   // working width for sums before saturation

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SP    = 2'd1;
  localparam logic [1:0] CMD_ERR   = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_KD   = 3'd2;
  localparam logic [2:0] REG_LOW  = 3'd3;
  localparam logic [2:0] REG_HIGH = 3'd4;
  localparam logic [2:0] REG_WG   = 3'd5;
  localparam logic [2:0] REG_TAU  = 3'd6;
  localparam logic [2:0] REG_DOM  = 3'd7;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [DW-1:0] setpoint;
    logic signed [DW-1:0] measurement;
    logic signed [DW-1:0] error_in;
    logic [TW-1:0]        dt;
    logic signed [DW-1:0] rate;
    logic                 rate_valid;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 saturated;
  } result_t;

  // saturate a working value to the data width
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] top;
    logic signed [XW-1:0] bot;
    top = XW'({1'b0, {(DW-1){1'b1}}});
    bot = -top - XW'(1);
    if (v > top) return top[DW-1:0];
    else if (v < bot) return bot[DW-1:0];
    else return v[DW-1:0];
  endfunction

  // saturate a working value to the integrator width
  function automatic logic signed [AW-1:0] sat_aw(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] top;
    logic signed [XW-1:0] bot;
    top = XW'({1'b0, {(AW-1){1'b1}}});
    bot = -top - XW'(1);
    if (v > top) return top[AW-1:0];
    else if (v < bot) return bot[AW-1:0];
    else return v[AW-1:0];
  endfunction

  // saturate a full product to the unit operand width
  function automatic logic signed [WW-1:0] sat_ww(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] top;
    logic signed [PW-1:0] bot;
    top = PW'({1'b0, {(WW-1){1'b1}}});
    bot = -top - PW'(1);
    if (v > top) return top[WW-1:0];
    else if (v < bot) return bot[WW-1:0];
    else return v[WW-1:0];
  endfunction

endpackage

[rtl/pid_controller_antiwindup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Q16.16 PID step with derivative filter and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// One item is processed at a time. A reset or unused command finishes
// without using the arithmetic units. An update runs through one shared
// bit-serial multiplier and one bit-serial divider: two multiplies
// (proportional, derivative), plus one divide when the derivative is a
// difference quotient, plus one multiply and one divide when the filter is
// on, plus four multiplies when dt is nonzero (two when the integrator is
// held by the clamp). A finished result sits in an output register while
// the next item is taken.
module pid_controller_antiwindup import pidc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  item_t         item,
  output logic          result_valid,
  input  logic          result_ready,
  output result_t       result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [DW-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV1 = 4'd1;
  localparam logic [3:0] S_FMUL = 4'd2;
  localparam logic [3:0] S_FDIV = 4'd3;
  localparam logic [3:0] S_KPM  = 4'd4;
  localparam logic [3:0] S_KDM  = 4'd5;
  localparam logic [3:0] S_CLMP = 4'd6;
  localparam logic [3:0] S_KIM  = 4'd7;
  localparam logic [3:0] S_KIDT = 4'd8;
  localparam logic [3:0] S_WGM  = 4'd9;
  localparam logic [3:0] S_WGDT = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  // configuration
  logic signed [DW-1:0] kp, ki, kd, out_low, out_high, windup_gain;
  logic [TW-1:0]        filter_tau;
  logic                 deriv_on_meas;

  // controller state
  logic signed [AW-1:0] integral_acc;
  logic signed [DW-1:0] last_error, last_measurement, filtered_deriv;
  logic                 primed;

  // item work registers
  logic [3:0]           state;
  logic [1:0]           cmd_r;
  logic signed [DW-1:0] err_r, meas_r, deriv_r;
  logic [TW-1:0]        dt_r;
  logic signed [WW-1:0] raw_r, bw_r;
  logic signed [XW-1:0] inc_r;
  result_t              res_r;

  // arithmetic units
  logic                 mul_go, mul_done, div_go, div_done;
  logic signed [WW-1:0] mul_a, mul_b, div_a, div_q;
  logic [TW:0]          div_d;
  logic signed [PW-1:0] prod, prod_sh;

  // decode of the item at the port
  logic signed [DW:0]   err_wide, diff;
  logic signed [DW-1:0] err_in, rate_d;
  logic                 need_div;

  // post-processing of unit results
  logic signed [DW-1:0] rd, st;
  logic signed [WW-1:0] d2, raw_sum, dtw, hi64, lo64, outv64, bcalc;
  logic signed [XW-1:0] inc_sum;
  logic                 above, below, deeper, err_pos;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign prod_sh    = prod >>> FB;
  assign dtw        = WW'({1'b0, dt_r});

  always_comb begin
    err_wide = (DW+1)'(item.setpoint) - (DW+1)'(item.measurement);
    err_in   = (item.cmd == CMD_SP) ? sat_dw(XW'(err_wide)) : item.error_in;
    rate_d   = (item.cmd == CMD_SP) ? sat_dw(-XW'(item.rate)) : item.rate;
    if (item.cmd == CMD_SP && deriv_on_meas)
      diff = (DW+1)'(last_measurement) - (DW+1)'(item.measurement);
    else
      diff = (DW+1)'(err_in) - (DW+1)'(last_error);
    need_div = (kd != '0) && !item.rate_valid && primed && (item.dt != '0);
  end

  always_comb begin
    rd      = sat_dw(XW'(div_q));
    d2      = WW'(rd) - WW'(filtered_deriv);
    st      = sat_dw(XW'(filtered_deriv) + XW'(div_q));
    raw_sum = raw_r + prod_sh[WW-1:0];
    hi64    = WW'(out_high);
    lo64    = WW'(out_low);
    above   = raw_r > hi64;
    below   = raw_r < lo64;
    outv64  = above ? hi64 : (below ? lo64 : raw_r);
    bcalc   = outv64 - raw_r;
    err_pos = !err_r[DW-1] && (err_r != '0);
    deeper  = (above && err_pos) || (below && err_r[DW-1]);
    inc_sum = inc_r + prod_sh[XW-1:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp            <= '0;
      ki            <= '0;
      kd            <= '0;
      out_low       <= {1'b1, {(DW-1){1'b0}}};
      out_high      <= {1'b0, {(DW-1){1'b1}}};
      windup_gain   <= '0;
      filter_tau    <= '0;
      deriv_on_meas <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KP:   kp            <= cfg_data;
        REG_KI:   ki            <= cfg_data;
        REG_KD:   kd            <= cfg_data;
        REG_LOW:  out_low       <= cfg_data;
        REG_HIGH: out_high      <= cfg_data;
        REG_WG:   windup_gain   <= cfg_data;
        REG_TAU:  filter_tau    <= cfg_data[TW-1:0];
        REG_DOM:  deriv_on_meas <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      mul_go           <= 1'b0;
      div_go           <= 1'b0;
      result_valid     <= 1'b0;
      integral_acc     <= '0;
      last_error       <= '0;
      last_measurement <= '0;
      filtered_deriv   <= '0;
      primed           <= 1'b0;
    end else begin
      // start pulses last one cycle; a unit is never restarted right away
      if (mul_go) mul_go <= 1'b0;
      if (div_go) div_go <= 1'b0;
      if (result_valid && result_ready && state != S_FIN) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cmd_r  <= item.cmd;
            err_r  <= err_in;
            meas_r <= item.measurement;
            dt_r   <= item.dt;
            res_r  <= '0;
            if (item.cmd == CMD_CLEAR) begin
              integral_acc     <= '0;
              last_error       <= '0;
              last_measurement <= '0;
              filtered_deriv   <= '0;
              primed           <= 1'b0;
              state            <= S_FIN;
            end else if (item.cmd == CMD_NOP) begin
              state <= S_FIN;
            end else if (need_div) begin
              div_go <= 1'b1;
              div_a  <= WW'(diff) <<< FB;
              div_d  <= {1'b0, item.dt};
              state  <= S_DIV1;
            end else begin
              deriv_r <= ((kd != '0) && item.rate_valid) ? rate_d : '0;
              mul_go  <= 1'b1;
              mul_a   <= WW'(kp);
              mul_b   <= WW'(err_in);
              state   <= S_KPM;
            end
          end
        end
        S_DIV1: begin
          if (div_done) begin
            mul_go <= 1'b1;
            if (filter_tau != '0) begin
              mul_a <= d2;
              mul_b <= dtw;
              state <= S_FMUL;
            end else begin
              deriv_r <= rd;
              mul_a   <= WW'(kp);
              mul_b   <= WW'(err_r);
              state   <= S_KPM;
            end
          end
        end
        S_FMUL: begin
          if (mul_done) begin
            div_go <= 1'b1;
            div_a  <= prod[WW-1:0];
            div_d  <= {1'b0, filter_tau} + {1'b0, dt_r};
            state  <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            filtered_deriv <= st;
            deriv_r        <= st;
            mul_go         <= 1'b1;
            mul_a          <= WW'(kp);
            mul_b          <= WW'(err_r);
            state          <= S_KPM;
          end
        end
        S_KPM: begin
          if (mul_done) begin
            raw_r  <= prod_sh[WW-1:0] + WW'(integral_acc);
            mul_go <= 1'b1;
            mul_a  <= WW'(kd);
            mul_b  <= WW'(deriv_r);
            state  <= S_KDM;
          end
        end
        S_KDM: begin
          if (mul_done) begin
            raw_r <= raw_sum;
            state <= S_CLMP;
          end
        end
        S_CLMP: begin
          bw_r            <= bcalc;
          res_r.drive     <= outv64[DW-1:0];
          res_r.saturated <= (outv64 != raw_r);
          inc_r           <= '0;
          if (dt_r == '0) begin
            last_error <= err_r;
            if (cmd_r == CMD_SP) last_measurement <= meas_r;
            primed <= 1'b1;
            state  <= S_FIN;
          end else if (!deeper) begin
            mul_go <= 1'b1;
            mul_a  <= WW'(ki);
            mul_b  <= WW'(err_r);
            state  <= S_KIM;
          end else begin
            mul_go <= 1'b1;
            mul_a  <= WW'(windup_gain);
            mul_b  <= bcalc;
            state  <= S_WGM;
          end
        end
        S_KIM: begin
          if (mul_done) begin
            mul_go <= 1'b1;
            mul_a  <= sat_ww(prod_sh);
            mul_b  <= dtw;
            state  <= S_KIDT;
          end
        end
        S_KIDT: begin
          if (mul_done) begin
            inc_r  <= prod_sh[XW-1:0];
            mul_go <= 1'b1;
            mul_a  <= WW'(windup_gain);
            mul_b  <= bw_r;
            state  <= S_WGM;
          end
        end
        S_WGM: begin
          if (mul_done) begin
            mul_go <= 1'b1;
            mul_a  <= sat_ww(prod_sh);
            mul_b  <= dtw;
            state  <= S_WGDT;
          end
        end
        S_WGDT: begin
          if (mul_done) begin
            integral_acc <= sat_aw(XW'(integral_acc) + inc_sum);
            last_error   <= err_r;
            if (cmd_r == CMD_SP) last_measurement <= meas_r;
            primed <= 1'b1;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          // wait for the output register to free up
          if (!result_valid || result_ready) begin
            result       <= res_r;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pidc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  pidc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q)
  );

  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_FMUL || state == S_KPM || state == S_KDM ||
                  state == S_KIM || state == S_KIDT || state == S_WGM ||
                  state == S_WGDT))
    else $error("multiplier result outside a waiting step");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV1 || state == S_FDIV))
    else $error("divider result outside a waiting step");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.cmd == CMD_CLEAR) |=> !primed)
    else $error("clear command left state primed");
  a_unit_excl: assert property (@(posedge clk) disable iff (rst) !(mul_go && div_go))
    else $error("both arithmetic units started together");

endmodule

[rtl/pidc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_mul
// Bit-serial signed multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidc_mul import pidc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [WW-1:0] a,
  input  logic signed [WW-1:0] b,
  output logic                 done,
  output logic signed [PW-1:0] prod
);

  logic          busy;
  logic [5:0]    cnt;
  logic [WW-1:0] ma;
  logic [WW-1:0] hi;
  logic [WW-1:0] lo;
  logic          neg;
  logic [WW:0]   sum;
  logic [PW-1:0] mag;

  // add the multiplicand when the low multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, ma} : {(WW+1){1'b0}});
  assign mag = {sum, lo[WW-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(WW - 1);
        ma   <= a[WW-1] ? WW'(-a) : WW'(a);
        lo   <= b[WW-1] ? WW'(-b) : WW'(b);
        hi   <= '0;
        neg  <= a[WW-1] ^ b[WW-1];
      end else if (busy) begin
        hi  <= sum[WW:1];
        lo  <= {sum[0], lo[WW-1:1]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          prod <= neg ? -$signed(mag) : $signed(mag);
        end
      end
    end
  end

  // an operation steps through every multiplier bit after start
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done held");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");

endmodule

[rtl/pidc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_div
// Restoring divider: signed 64-bit dividend by unsigned nonzero 25-bit
// divisor, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pidc_div import pidc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [WW-1:0] dividend,
  input  logic [TW:0]          divisor,
  output logic                 done,
  output logic signed [WW-1:0] quot
);

  logic          busy;
  logic [5:0]    cnt;
  logic [TW:0]   d;
  logic [TW:0]   rem;
  logic [WW-1:0] q;
  logic          neg;
  logic [TW+1:0] trial;
  logic          qbit;
  logic [TW+1:0] rem_next;
  logic [WW-1:0] q_next;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem, q[WW-1]};
    qbit     = trial >= {1'b0, d};
    rem_next = qbit ? trial - {1'b0, d} : trial;
    q_next   = {q[WW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(WW - 1);
        d    <= divisor;
        rem  <= '0;
        q    <= dividend[WW-1] ? WW'(-dividend) : WW'(dividend);
        neg  <= dividend[WW-1];
      end else if (busy) begin
        rem <= rem_next[TW:0];
        q   <= q_next;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg ? -$signed(q_next) : $signed(q_next);
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_rem_range: assert property (@(posedge clk) disable iff (rst) busy |-> rem < d)
    else $error("divider remainder out of range");

endmodule
